/* rtl/spt_pkg.sv */
// ----------------------------------------------------------------------------
// spt_pkg
// Shared widths, codes and types of the sorted pair priority table.
// ----------------------------------------------------------------------------
package spt_pkg;

  localparam int MAX_PAIRS  = 64;
  localparam int IDX_W      = $clog2(MAX_PAIRS);
  localparam int CNT_W      = $clog2(MAX_PAIRS + 1);

  localparam int CPRIO_W    = 32;
  localparam int PRIO_W     = 64;
  localparam int REF_W      = 4;
  localparam int TXH_W      = 32;
  localparam int TXL_W      = 64;
  localparam int RIDX_W     = 6;
  localparam int POS_W      = 6;
  localparam int PCNT_W     = 7;
  localparam int STAT_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_IS_CONTROLLING = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAIR_LIMIT     = 2'd1;

  localparam logic [PCNT_W-1:0] PAIR_LIMIT_RST = 7'd64;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_BAD_INDEX = 2'd2
  } status_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [REF_W-1:0]  lref;
    logic [REF_W-1:0]  rref;
    logic [TXH_W-1:0]  txh;
    logic [TXL_W-1:0]  txl;
  } entry_t;

  typedef struct packed {
    logic   ins_en;
    entry_t ent;
  } cell_cmd_t;

endpackage

/* rtl/spt_in_if.sv */
// ----------------------------------------------------------------------------
// spt_in_if
// Item channel: insert or read requests.
// ----------------------------------------------------------------------------
interface spt_in_if import spt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               kind;
  logic [CPRIO_W-1:0] local_priority;
  logic [CPRIO_W-1:0] remote_priority;
  logic [REF_W-1:0]   local_ref;
  logic [REF_W-1:0]   remote_ref;
  logic [TXH_W-1:0]   txid_high;
  logic [TXL_W-1:0]   txid_low;
  logic [RIDX_W-1:0]  read_index;

  modport source (
    output valid, kind, local_priority, remote_priority, local_ref, remote_ref,
           txid_high, txid_low, read_index,
    input  ready
  );
  modport sink (
    input  valid, kind, local_priority, remote_priority, local_ref, remote_ref,
           txid_high, txid_low, read_index,
    output ready
  );
endinterface

/* rtl/spt_out_if.sv */
// ----------------------------------------------------------------------------
// spt_out_if
// Result channel: one beat per item.
// ----------------------------------------------------------------------------
interface spt_out_if import spt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [POS_W-1:0]  position;
  logic [PCNT_W-1:0] pair_count;
  logic [REF_W-1:0]  out_local_ref;
  logic [REF_W-1:0]  out_remote_ref;
  logic [PRIO_W-1:0] out_priority;
  logic [TXH_W-1:0]  out_txid_high;
  logic [TXL_W-1:0]  out_txid_low;

  modport source (
    output valid, status, position, pair_count, out_local_ref, out_remote_ref,
           out_priority, out_txid_high, out_txid_low,
    input  ready
  );
  modport sink (
    input  valid, status, position, pair_count, out_local_ref, out_remote_ref,
           out_priority, out_txid_high, out_txid_low,
    output ready
  );
endinterface

/* rtl/spt_cfg_if.sv */
// ----------------------------------------------------------------------------
// spt_cfg_if
// Register write channel.
// ----------------------------------------------------------------------------
interface spt_cfg_if import spt_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink (input valid, reg_index, wdata, output ready);
endinterface

/* rtl/spt_prio_calc.sv */
// ----------------------------------------------------------------------------
// spt_prio_calc
// Pair priority: min(G,D)*2^32 + 2*max(G,D) + (G > D), modulo 2^64.
// ----------------------------------------------------------------------------
module spt_prio_calc import spt_pkg::*; (
  input  logic               is_controlling,
  input  logic [CPRIO_W-1:0] local_priority,
  input  logic [CPRIO_W-1:0] remote_priority,
  output logic [PRIO_W-1:0]  prio
);

  logic [CPRIO_W-1:0] g;
  logic [CPRIO_W-1:0] d;
  logic [CPRIO_W-1:0] mn;
  logic [CPRIO_W-1:0] mx;
  logic               g_gt_d;

  always_comb begin
    g      = is_controlling ? local_priority : remote_priority;
    d      = is_controlling ? remote_priority : local_priority;
    g_gt_d = (g > d);
    mn     = g_gt_d ? d : g;
    mx     = g_gt_d ? g : d;
    prio   = {mn, {CPRIO_W{1'b0}}} + {{(PRIO_W-CPRIO_W-1){1'b0}}, mx, 1'b0}
           + {{(PRIO_W-1){1'b0}}, g_gt_d};
  end

endmodule

/* rtl/spt_cell.sv */
// ----------------------------------------------------------------------------
// spt_cell
// One table slot: compare against the new pair, then take the new pair or
// the left neighbor's entry.
// ----------------------------------------------------------------------------
module spt_cell import spt_pkg::*; (
  input  logic      clk,
  input  cell_cmd_t cmd,
  input  logic      occupied,
  input  logic      left_go,
  input  entry_t    left_ent,
  output logic      go,
  output entry_t    ent
);

  entry_t ent_r;
  entry_t ent_nxt;

  assign go  = !occupied || (cmd.ent.prio >= ent_r.prio);
  assign ent = ent_r;

  always_comb begin
    ent_nxt = ent_r;
    if (cmd.ins_en && go) begin
      ent_nxt = left_go ? left_ent : cmd.ent;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

endmodule

/* rtl/sorted_pair_priority_table.sv */
// ----------------------------------------------------------------------------
// sorted_pair_priority_table
// Candidate pairs held in descending pair-priority order.
// ----------------------------------------------------------------------------
// Each item goes through an accept cycle, which computes the 64-bit pair
// priority and registers the item, and then an execute cycle, which lets all
// MAX_PAIRS cells compare against it in parallel, shift the lower entries one
// slot down and write the result register. The execute cycle waits while an
// earlier result beat is still unclaimed, and no new item is accepted until
// the current one has executed. Reads return the slot selected by read_index
// in the same execute cycle. The config channel is always ready; table
// entries need no clearing after reset.
module sorted_pair_priority_table import spt_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  spt_in_if.sink    in_ch,
  spt_out_if.source out_ch,
  spt_cfg_if.sink   cfg_ch
);

  state_t            state_r;
  state_t            state_nxt;
  logic              is_ctl_r;
  logic [PCNT_W-1:0] pair_limit_r;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;

  logic              kind_r;
  entry_t            item_r;
  logic [RIDX_W-1:0] ridx_r;
  logic [PRIO_W-1:0] new_prio;

  logic              out_valid_r;
  status_t           out_status_r;
  logic [POS_W-1:0]  out_pos_r;
  logic [PCNT_W-1:0] out_cnt_r;
  entry_t            out_ent_r;

  logic              in_fire;
  logic              exec_fire;
  logic              full;
  logic              rd_bad;
  cell_cmd_t         cmd;
  logic [MAX_PAIRS-1:0] go;
  logic [MAX_PAIRS-1:0] occ;
  logic [MAX_PAIRS-1:0] therm;
  entry_t            cell_ent [MAX_PAIRS];
  logic [IDX_W-1:0]  ins_pos;

  status_t           res_status;
  logic [POS_W-1:0]  res_pos;
  entry_t            res_ent;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      is_ctl_r     <= 1'b0;
      pair_limit_r <= PAIR_LIMIT_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.reg_index)
        CFG_IS_CONTROLLING: is_ctl_r <= cfg_ch.wdata[0];
        CFG_PAIR_LIMIT:     pair_limit_r <= cfg_ch.wdata;
        default: ;
      endcase
    end
  end

  spt_prio_calc u_prio (
    .is_controlling  (is_ctl_r),
    .local_priority  (in_ch.local_priority),
    .remote_priority (in_ch.remote_priority),
    .prio            (new_prio)
  );

  assign in_fire   = in_ch.valid && in_ch.ready;
  assign exec_fire = (state_r == ST_EXEC) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_fire) state_nxt = ST_EXEC;
      ST_EXEC: if (exec_fire) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = (state_r == ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_r      <= in_ch.kind;
      ridx_r      <= in_ch.read_index;
      item_r.prio <= new_prio;
      item_r.lref <= in_ch.local_ref;
      item_r.rref <= in_ch.remote_ref;
      item_r.txh  <= in_ch.txid_high;
      item_r.txl  <= in_ch.txid_low;
    end
  end

  assign full   = (32'(count_r) >= 32'(pair_limit_r)) || (32'(count_r) >= MAX_PAIRS);
  assign rd_bad = (32'(ridx_r) >= 32'(count_r));

  assign cmd.ins_en = exec_fire && (kind_r == KIND_INSERT) && !full;
  assign cmd.ent    = item_r;

  for (genvar i = 0; i < MAX_PAIRS; i++) begin : g_cell
    assign occ[i]   = (32'(i) < 32'(count_r));
    assign therm[i] = !go[i];
    if (i == 0) begin : g_head
      spt_cell u_cell (
        .clk      (clk),
        .cmd      (cmd),
        .occupied (occ[i]),
        .left_go  (1'b0),
        .left_ent ('0),
        .go       (go[i]),
        .ent      (cell_ent[i])
      );
    end else begin : g_body
      spt_cell u_cell (
        .clk      (clk),
        .cmd      (cmd),
        .occupied (occ[i]),
        .left_go  (go[i-1]),
        .left_ent (cell_ent[i-1]),
        .go       (go[i]),
        .ent      (cell_ent[i])
      );
    end
  end

  always_comb begin
    ins_pos = '0;
    for (int k = 1; k < MAX_PAIRS; k++) begin
      if (therm[k-1] && !therm[k]) begin
        ins_pos = ins_pos | IDX_W'(k);
      end
    end
  end

  always_comb begin
    res_status = STAT_OK;
    res_pos    = '0;
    res_ent    = '0;
    count_nxt  = count_r;
    if (kind_r == KIND_READ) begin
      res_pos = POS_W'(ridx_r);
      if (rd_bad) begin
        res_status = STAT_BAD_INDEX;
      end else begin
        res_ent = cell_ent[IDX_W'(ridx_r)];
      end
    end else if (full) begin
      res_status = STAT_FULL;
    end else begin
      res_pos   = POS_W'(ins_pos);
      res_ent   = item_r;
      count_nxt = count_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (exec_fire) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      out_status_r <= res_status;
      out_pos_r    <= res_pos;
      out_cnt_r    <= PCNT_W'(count_nxt);
      out_ent_r    <= res_ent;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_status_r;
  assign out_ch.position       = out_pos_r;
  assign out_ch.pair_count     = out_cnt_r;
  assign out_ch.out_local_ref  = out_ent_r.lref;
  assign out_ch.out_remote_ref = out_ent_r.rref;
  assign out_ch.out_priority   = out_ent_r.prio;
  assign out_ch.out_txid_high  = out_ent_r.txh;
  assign out_ch.out_txid_low   = out_ent_r.txl;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= MAX_PAIRS)
    else $error("pair count beyond table depth");

  a_sorted_row: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins_en |-> ((therm & (therm + MAX_PAIRS'(1))) == '0))
    else $error("cell compare results not a prefix, table out of order");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins_en |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("insert did not advance pair count");

  a_out_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_EXEC))
    else $error("result beat raised outside execute cycle");

endmodule
